// ===== rtl/core/bhc_pkg.sv =====
// ----------------------------------------------------------------------------
// bhc_pkg: shared definitions of the biquad high-pass cascade
// Widths, coefficient table, datapath commands and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

  localparam int unsigned SAMPLE_WIDTH   = 16;
  localparam int unsigned COEF_FRAC_BITS = 28;

  localparam int unsigned ST_W    = 40;
  localparam int unsigned ST_FRAC = 30;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned TERM_W  = 44;
  localparam int unsigned WIDE_W  = 46;
  localparam int unsigned PROD_W  = 74;
  localparam int unsigned SPLIT   = 20;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ST_W-1:0]   st_t;

  typedef enum logic [2:0] {
    OP_B0 = 3'd0,
    OP_B1 = 3'd1,
    OP_B2 = 3'd2,
    OP_A1 = 3'd3,
    OP_A2 = 3'd4
  } op_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic rnd;
    logic acc;
    logic finish;
    logic stage;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } status_t;

  // b0, b1, b2, a1, a2 of each stage with 30 fraction bits.
  localparam coef_t COEF_Q30 [2][5] = '{
    '{32'sd990536797, -32'sd1981073605, 32'sd990536797,
      -32'sd1975868104, 32'sd912537281},
    '{32'sd1073741824, 32'sh8000_0000, 32'sd1073741824,
      -32'sd2062971974, 32'sd999637070}
  };

  localparam logic signed [WIDE_W-1:0] ST_MAX_W = (46'sd1 <<< (ST_W - 1)) - 46'sd1;
  localparam logic signed [WIDE_W-1:0] ST_MIN_W = -(46'sd1 <<< (ST_W - 1));

  function automatic coef_t coef_at(logic stage, op_e op, int unsigned frac);
    logic signed [COEF_W:0] q;
    int unsigned sh;
    sh = ST_FRAC - frac;
    q  = {COEF_Q30[stage][op][COEF_W-1], COEF_Q30[stage][op]};
    if (sh != 0) begin
      q = (q + (33'sd1 <<< (sh - 1))) >>> sh;
    end
    return q[COEF_W-1:0];
  endfunction

  function automatic st_t sat_st(logic signed [WIDE_W-1:0] v);
    st_t r;
    if (v > ST_MAX_W) begin
      r = ST_MAX_W[ST_W-1:0];
    end else if (v < ST_MIN_W) begin
      r = ST_MIN_W[ST_W-1:0];
    end else begin
      r = v[ST_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bhc_in_if.sv =====
// ----------------------------------------------------------------------------
// bhc_in_if: input sample channel
// Valid/ready channel carrying one audio sample and its last-sample marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhc_in_if #(
  parameter int unsigned SampleWidth = bhc_pkg::SAMPLE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bhc_out_if.sv =====
// ----------------------------------------------------------------------------
// bhc_out_if: output sample channel
// Valid/ready channel carrying one filtered sample, its clip flag and marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhc_out_if #(
  parameter int unsigned SampleWidth = bhc_pkg::SAMPLE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_out;
  logic                          clipped;
  logic                          last_out;

  modport source (output valid, output sample_out, output clipped, output last_out,
                  input ready);
  modport sink   (input valid, input sample_out, input clipped, input last_out,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/biquad_highpass_cascade_top.sv =====
// ----------------------------------------------------------------------------
// biquad_highpass_cascade_top: fourth-order high-pass filter
// Two cascaded transposed direct form II biquads with fixed coefficients.
//
// The sample_i channel takes one signed sample and a last-sample marker per
// transaction. The result_o channel returns one transaction per input: the
// filtered sample, rounded and saturated, a clip flag and the copied marker.
// A sample is accepted only while the sequencer is idle, so a new sample is
// taken only once the previous one has been computed. The ten coefficient
// products each take a multiply, a round and an accumulate step on the one
// shared split multiplier; after the last of them the result is written to
// the output register and becomes valid. The finished result sits in an
// output register, so a stalled receiver holds only the sequencer's final
// step; the next sample is computed while the previous result waits.
// Reset clears all delay values and the output valid flag. After a sample
// with the marker set, all delay values return to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_highpass_cascade_top #(
  parameter int unsigned SampleWidth  = bhc_pkg::SAMPLE_WIDTH,
  parameter int unsigned CoefFracBits = bhc_pkg::COEF_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bhc_in_if.sink    sample_i,
  bhc_out_if.source result_o
);
  import bhc_pkg::*;

  cmd_t    cmd;
  status_t status;

  bhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bhc_datapath #(
    .SampleWidth  (SampleWidth),
    .CoefFracBits (CoefFracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample_i.sample_in),
    .last_i      (sample_i.last_in),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .sample_o    (result_o.sample_out),
    .clipped_o   (result_o.clipped),
    .last_o      (result_o.last_out)
  );

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (sample_i.valid && sample_i.ready))
    else $error("Sample loaded without an input transaction.");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.finish))
    else $error("Output became valid without a finished computation.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!result_o.valid || result_o.ready))
    else $error("Result register overwritten while stalled.");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !sample_i.ready)
    else $error("Input ready right after a sample was accepted.");

endmodule

`default_nettype wire

// ===== rtl/core/bhc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhc_ctrl: sequencer of the biquad cascade
// Steps the shared multiplier through the ten products of both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bhc_pkg::status_t status_i,
  output bhc_pkg::cmd_t    cmd_o
);
  import bhc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_RND  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   stage_q, stage_d;
  op_e    op_q, op_d, op_next;

  always_comb begin
    unique case (op_q)
      OP_B0:   op_next = OP_B1;
      OP_B1:   op_next = OP_A1;
      OP_A1:   op_next = OP_B2;
      OP_B2:   op_next = OP_A2;
      default: op_next = OP_B0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    stage_d      = stage_q;
    op_d         = op_q;
    cmd_o        = '0;
    cmd_o.stage  = stage_q;
    cmd_o.op     = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          stage_d    = 1'b0;
          op_d       = OP_B0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (op_q == OP_A2) begin
          if (stage_q) begin
            state_d = ST_OUT;
          end else begin
            stage_d = 1'b1;
            op_d    = OP_B0;
            state_d = ST_MUL;
          end
        end else begin
          op_d    = op_next;
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!status_i.out_stall) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= 1'b0;
      op_q    <= OP_B0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      op_q    <= op_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bhc_datapath.sv =====
// ----------------------------------------------------------------------------
// bhc_datapath: arithmetic and delay state of the biquad cascade
// Split multiplier, rounding, accumulation, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_datapath #(
  parameter int unsigned SampleWidth  = bhc_pkg::SAMPLE_WIDTH,
  parameter int unsigned CoefFracBits = bhc_pkg::COEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bhc_pkg::cmd_t                 cmd_i,
  output bhc_pkg::status_t              status_o,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          last_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SampleWidth-1:0] sample_o,
  output logic                          clipped_o,
  output logic                          last_o
);
  import bhc_pkg::*;

  localparam int unsigned Sh = ST_FRAC + 1 - SampleWidth;
  localparam logic signed [PROD_W-1:0] ProdHalf = PROD_W'(1) <<< (CoefFracBits - 1);
  localparam logic signed [ST_W:0] OutHalf = (ST_W + 1)'(1) <<< (Sh - 1);
  localparam logic signed [ST_W:0] SMax = (ST_W + 1)'((64'd1 << (SampleWidth - 1)) - 64'd1);
  localparam logic signed [ST_W:0] SMin = -SMax - (ST_W + 1)'(1);

  st_t u_q, y_q;
  logic last_q;
  st_t z_first_q [2];
  st_t z_second_q [2];
  logic signed [COEF_W+SPLIT:0]        plo_q, plo_d;
  logic signed [COEF_W+ST_W-SPLIT-1:0] phi_q, phi_d;
  logic signed [TERM_W-1:0]            term_q, term_d, sum_q;
  logic out_valid_q, clipped_q, last_out_q;
  logic signed [SampleWidth-1:0] sample_q, sample_d;
  logic clipped_d;

  logic signed [ST_FRAC:0] x_ext;
  st_t operand, zsel0, zsel1, acc_sat_y, acc_sat_z;
  coef_t coef_v;
  logic signed [SPLIT:0]        a_lo;
  logic signed [ST_W-SPLIT-1:0] a_hi;
  logic signed [PROD_W-1:0] full;
  logic signed [WIDE_W-1:0] t_w, diff_w, sum_y_w, sum_z_w;
  logic signed [ST_W:0] y_sum, y_rnd;
  logic uses_u;

  assign x_ext   = {sample_i, {Sh{1'b0}}};
  assign uses_u  = (cmd_i.op == OP_B0) || (cmd_i.op == OP_B1) || (cmd_i.op == OP_B2);
  assign operand = uses_u ? u_q : y_q;
  assign coef_v  = coef_at(cmd_i.stage, cmd_i.op, CoefFracBits);
  assign a_lo    = {1'b0, operand[SPLIT-1:0]};
  assign a_hi    = operand[ST_W-1:SPLIT];
  assign plo_d   = coef_v * a_lo;
  assign phi_d   = coef_v * a_hi;

  assign full   = (PROD_W'(phi_q) <<< SPLIT) + PROD_W'(plo_q) + ProdHalf;
  assign term_d = full[CoefFracBits +: TERM_W];

  assign zsel0     = cmd_i.stage ? z_second_q[0] : z_first_q[0];
  assign zsel1     = cmd_i.stage ? z_second_q[1] : z_first_q[1];
  assign t_w       = WIDE_W'(term_q);
  assign sum_y_w   = t_w + WIDE_W'(zsel0);
  assign sum_z_w   = t_w + WIDE_W'(zsel1);
  assign diff_w    = WIDE_W'(sum_q) - t_w;
  assign acc_sat_y = sat_st(sum_y_w);
  assign acc_sat_z = sat_st(diff_w);

  assign y_sum = (ST_W + 1)'(y_q) + OutHalf;
  assign y_rnd = y_sum >>> Sh;

  always_comb begin
    if (y_rnd > SMax) begin
      sample_d  = SMax[SampleWidth-1:0];
      clipped_d = 1'b1;
    end else if (y_rnd < SMin) begin
      sample_d  = SMin[SampleWidth-1:0];
      clipped_d = 1'b1;
    end else begin
      sample_d  = y_rnd[SampleWidth-1:0];
      clipped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_q    <= ST_W'(x_ext);
      last_q <= last_i;
    end
    if (cmd_i.mul) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (cmd_i.rnd) begin
      term_q <= term_d;
    end
    if (cmd_i.acc) begin
      unique case (cmd_i.op)
        OP_B0: y_q <= acc_sat_y;
        OP_B1: sum_q <= sum_z_w[TERM_W-1:0];
        OP_B2: sum_q <= term_q;
        OP_A2: begin
          if (!cmd_i.stage) begin
            u_q <= y_q;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      sample_q   <= sample_d;
      clipped_q  <= clipped_d;
      last_out_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_first_q[0]  <= '0;
      z_first_q[1]  <= '0;
      z_second_q[0] <= '0;
      z_second_q[1] <= '0;
    end else if (cmd_i.finish && last_q) begin
      z_first_q[0]  <= '0;
      z_first_q[1]  <= '0;
      z_second_q[0] <= '0;
      z_second_q[1] <= '0;
    end else if (cmd_i.acc && (cmd_i.op == OP_A1)) begin
      if (cmd_i.stage) begin
        z_second_q[0] <= acc_sat_z;
      end else begin
        z_first_q[0] <= acc_sat_z;
      end
    end else if (cmd_i.acc && (cmd_i.op == OP_A2)) begin
      if (cmd_i.stage) begin
        z_second_q[1] <= acc_sat_z;
      end else begin
        z_first_q[1] <= acc_sat_z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign clipped_o   = clipped_q;
  assign last_o      = last_out_q;

endmodule

`default_nettype wire
